// ----- sv/d2e_pkg.sv -----
// Package for the direction to equirectangular pixel core.
// Holds shared widths, angle constants, the arctangent table and the
// CORDIC step; every other file of the block imports it.
package d2e_pkg;

   // Defaults for the top-level parameters.
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int ANGLE_STAGES_DEF = 16;
   localparam int MAX_STAGES       = 32;

   // Binary angle: one full turn is 2^32.
   localparam int ANGLE_BITS = 32;
   localparam logic [ANGLE_BITS-1:0] QUARTER_TURN       = 32'h4000_0000;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN          = 32'h8000_0000;
   localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

   // Square root datapath: 64-bit radicand, 32-bit root.
   localparam int RAD_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int REM_W     = 35;
   localparam int SQ_CELLS  = ROOT_W;

   // CORDIC datapath.
   localparam int VEC_W = 36;
   localparam int ANG_W = 33;

   // Configuration registers and result fields.
   localparam int HEIGHT_W   = 14;
   localparam int WIDTH_W    = 15;
   localparam int COL_W      = 14;
   localparam int ROW_W      = 13;
   localparam int RSP_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = CSR_IDX_W'(1);

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 14'd1024;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 15'd2048;

   // atan(2^-i) in binary angle units, rounded to nearest.
   localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic x_zero;
      logic x_neg;
      logic y_zero;
      logic y_neg;
      logic z_zero;
      logic z_neg;
   } d2e_flags_type;

   // Magnitudes already scaled up to 32 bits, plus the sign and zero flags.
   typedef struct packed {
      logic [ANGLE_BITS-1:0] ax_s;
      logic [ANGLE_BITS-1:0] ay_s;
      logic [ANGLE_BITS-1:0] az_s;
      d2e_flags_type         flags;
   } d2e_side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } d2e_sqrt_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] p;
      logic signed [VEC_W-1:0] q;
      logic signed [ANG_W-1:0] ang;
   } d2e_vec_type;

   typedef struct packed {
      logic room;
      logic full;
   } d2e_skid_stat_type;

   // One vectoring rotation: drive q toward zero, accumulate the angle.
   function automatic d2e_vec_type cordic_step(input d2e_vec_type v,
                                               input logic [4:0] sh,
                                               input logic [ANGLE_BITS-1:0] atan);
      logic signed [VEC_W-1:0] p;
      logic signed [VEC_W-1:0] q;
      logic signed [VEC_W-1:0] dp;
      logic signed [VEC_W-1:0] dq;
      logic signed [ANG_W-1:0] a;
      logic signed [ANG_W-1:0] da;
      d2e_vec_type r;
      p  = v.p;
      q  = v.q;
      a  = v.ang;
      dp = p >>> sh;
      dq = q >>> sh;
      da = $signed({1'b0, atan});
      if (!q[VEC_W-1]) begin
         r.p   = p + dq;
         r.q   = q - dp;
         r.ang = a + da;
      end else begin
         r.p   = p - dq;
         r.q   = q + dp;
         r.ang = a - da;
      end
      return r;
   endfunction

   // Limit a first-quadrant angle to [0, quarter turn].
   function automatic logic [ANGLE_BITS-1:0] clamp_angle(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] lim;
      lim = $signed({1'b0, QUARTER_TURN});
      if (a[ANG_W-1]) begin
         return '0;
      end else if (a > lim) begin
         return QUARTER_TURN;
      end else begin
         return a[ANGLE_BITS-1:0];
      end
   endfunction

endpackage

// ----- sv/d2e_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cell.
// Depends on d2e_pkg for the datapath structs.
module d2e_sqrt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  d2e_pkg::d2e_side_type in_side,
   input  d2e_pkg::d2e_sqrt_type in_data,
   output logic                 out_valid,
   output d2e_pkg::d2e_side_type out_side,
   output d2e_pkg::d2e_sqrt_type out_data
);
   import d2e_pkg::*;

   logic         valid_ff;
   d2e_side_type side_ff;
   d2e_sqrt_type data_ff;
   d2e_sqrt_type data_in;
   logic [REM_W-1:0] rem_t;
   logic [REM_W-1:0] trial;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      rem_t = {in_data.rem[REM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
      trial = REM_W'({in_data.root, 2'b01});
      data_in.rad = in_data.rad << 2;
      if (rem_t >= trial) begin
         data_in.rem  = rem_t - trial;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_t;
         data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_data  = data_ff;

endmodule

// ----- sv/d2e_cordic_cell.sv -----
// One CORDIC stage for both the polar and the azimuth vector.
// Depends on d2e_pkg for the vector type, the step function and the atan table.
module d2e_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  d2e_pkg::d2e_side_type in_side,
   input  d2e_pkg::d2e_vec_type  in_theta,
   input  d2e_pkg::d2e_vec_type  in_phi,
   output logic                 out_valid,
   output d2e_pkg::d2e_side_type out_side,
   output d2e_pkg::d2e_vec_type  out_theta,
   output d2e_pkg::d2e_vec_type  out_phi
);
   import d2e_pkg::*;

   localparam logic [4:0]            SHIFT = 5'(STAGE);
   localparam logic [ANGLE_BITS-1:0] ATAN  = ATAN_TURNS[STAGE];

   logic         valid_ff;
   d2e_side_type side_ff;
   d2e_vec_type  theta_ff;
   d2e_vec_type  phi_ff;
   d2e_vec_type  theta_in;
   d2e_vec_type  phi_in;

   always_comb begin
      theta_in = cordic_step(in_theta, SHIFT, ATAN);
      phi_in   = cordic_step(in_phi, SHIFT, ATAN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= in_side;
         theta_ff <= theta_in;
         phi_ff   <= phi_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_theta = theta_ff;
   assign out_phi   = phi_ff;

endmodule

// ----- sv/d2e_skid.sv -----
// Two-entry output buffer that decouples the result channel from the pipeline.
// Depends on d2e_pkg for the status struct.
module d2e_skid #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  logic [WIDTH-1:0]          push_data,
   output d2e_pkg::d2e_skid_stat_type stat,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [WIDTH-1:0]          out_data
);
   import d2e_pkg::*;

   logic             head_v_ff;
   logic             head_v_in;
   logic [WIDTH-1:0] head_ff;
   logic [WIDTH-1:0] head_in;
   logic             spare_v_ff;
   logic             spare_v_in;
   logic [WIDTH-1:0] spare_ff;
   logic [WIDTH-1:0] spare_in;
   logic             pop;
   logic             room;
   logic             push;
   logic             take;

   assign pop  = head_v_ff && out_ready;
   assign room = !spare_v_ff || pop;
   assign push = push_valid && room;
   assign take = !head_v_ff || pop;

   always_comb begin
      head_v_in  = head_v_ff;
      head_in    = head_ff;
      spare_v_in = spare_v_ff;
      spare_in   = spare_ff;
      if (take) begin
         if (spare_v_ff) begin
            head_v_in  = 1'b1;
            head_in    = spare_ff;
            spare_v_in = push;
            spare_in   = push_data;
         end else begin
            head_v_in  = push;
            head_in    = push_data;
            spare_v_in = 1'b0;
         end
      end else if (push) begin
         spare_v_in = 1'b1;
         spare_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_v_ff  <= 1'b0;
         spare_v_ff <= 1'b0;
      end else begin
         head_v_ff  <= head_v_in;
         spare_v_ff <= spare_v_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
   end

   assign stat.room = room;
   assign stat.full = spare_v_ff;
   assign out_valid = head_v_ff;
   assign out_data  = head_ff;

endmodule

// ----- sv/direction_to_equirect_pixel_core.sv -----
// Maps a signed fixed-point view direction to the column and row of an
// equirectangular image. The block is fully pipelined and takes one item per
// clock while the output buffer has room. An item passes the input stages,
// the 32 one-bit square root cells, ANGLE_STAGES CORDIC cells and the angle
// and scale registers. A two-entry output buffer lets the block keep accepting
// items while one result waits; when both entries are held and the head waits,
// the whole pipeline stalls. Image size registers should only be written while
// no item is in flight. Depends on d2e_pkg, d2e_skid and the d2e cell modules.
module direction_to_equirect_pixel_core #(
   parameter int COORD_WIDTH  = d2e_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_STAGES = d2e_pkg::ANGLE_STAGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // dir_x, dir_y, dir_z (COORD_WIDTH bits each), then zero fill
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // texel_col [13:0], texel_row [26:14], then zero fill
   output logic [d2e_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             csr_we,
   input  logic [d2e_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [d2e_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import d2e_pkg::*;

   localparam int PRESCALE = ANGLE_BITS - COORD_WIDTH;
   localparam int SQ_W     = 2 * COORD_WIDTH;
   localparam int MCOL_W   = ANGLE_BITS + WIDTH_W;
   localparam int MROW_W   = ANGLE_BITS + HEIGHT_W;
   localparam int RFULL_W  = HEIGHT_W + 1;

   // Configuration registers.
   logic [HEIGHT_W-1:0] tex_height_ff;
   logic [HEIGHT_W-1:0] tex_height_in;
   logic [WIDTH_W-1:0]  tex_width_ff;
   logic [WIDTH_W-1:0]  tex_width_in;

   always_comb begin
      tex_height_in = tex_height_ff;
      tex_width_in  = tex_width_ff;
      if (csr_we) begin
         case (csr_idx)
            CSR_TEX_HEIGHT: tex_height_in = csr_wdata[HEIGHT_W-1:0];
            CSR_TEX_WIDTH:  tex_width_in  = csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_height_ff <= HEIGHT_RESET;
         tex_width_ff  <= WIDTH_RESET;
      end else begin
         tex_height_ff <= tex_height_in;
         tex_width_ff  <= tex_width_in;
      end
   end

   // Pipeline control.
   d2e_skid_stat_type skid_stat;
   logic              pipe_en;

   assign pipe_en    = skid_stat.room;
   assign req_tready = pipe_en;

   // Stage 1: magnitudes and flags.
   logic signed [COORD_WIDTH-1:0] dx;
   logic signed [COORD_WIDTH-1:0] dy;
   logic signed [COORD_WIDTH-1:0] dz;
   logic [COORD_WIDTH-1:0]        mx;
   logic [COORD_WIDTH-1:0]        my;
   logic [COORD_WIDTH-1:0]        mz;
   logic                          s1_v_ff;
   d2e_side_type                  s1_side_ff;
   d2e_side_type                  s1_side_in;

   always_comb begin
      dx = req_tdata[0 +: COORD_WIDTH];
      dy = req_tdata[COORD_WIDTH +: COORD_WIDTH];
      dz = req_tdata[2*COORD_WIDTH +: COORD_WIDTH];
      // The negation of the most negative value wraps to the right magnitude.
      mx = dx[COORD_WIDTH-1] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
      my = dy[COORD_WIDTH-1] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);
      mz = dz[COORD_WIDTH-1] ? COORD_WIDTH'(-dz) : COORD_WIDTH'(dz);
      s1_side_in.ax_s = ANGLE_BITS'(mx) << PRESCALE;
      s1_side_in.ay_s = ANGLE_BITS'(my) << PRESCALE;
      s1_side_in.az_s = ANGLE_BITS'(mz) << PRESCALE;
      s1_side_in.flags.x_zero = (dx == '0);
      s1_side_in.flags.x_neg  = dx[COORD_WIDTH-1];
      s1_side_in.flags.y_zero = (dy == '0);
      s1_side_in.flags.y_neg  = dy[COORD_WIDTH-1];
      s1_side_in.flags.z_zero = (dz == '0);
      s1_side_in.flags.z_neg  = dz[COORD_WIDTH-1];
   end

   // Stage 2: squares of the horizontal magnitudes.
   logic [COORD_WIDTH-1:0] ax_m;
   logic [COORD_WIDTH-1:0] az_m;
   logic                   s2_v_ff;
   d2e_side_type           s2_side_ff;
   logic [SQ_W-1:0]        s2_sqx_ff;
   logic [SQ_W-1:0]        s2_sqx_in;
   logic [SQ_W-1:0]        s2_sqz_ff;
   logic [SQ_W-1:0]        s2_sqz_in;

   always_comb begin
      ax_m = COORD_WIDTH'(s1_side_ff.ax_s >> PRESCALE);
      az_m = COORD_WIDTH'(s1_side_ff.az_s >> PRESCALE);
      s2_sqx_in = SQ_W'(ax_m) * SQ_W'(ax_m);
      s2_sqz_in = SQ_W'(az_m) * SQ_W'(az_m);
   end

   // Stage 3: radicand, scaled so the root lands in the 32-bit angle frame.
   logic [SQ_W-1:0]                sum_sq;
   logic [SQ_CELLS:0]              sq_v;
   d2e_side_type                   sq_side [SQ_CELLS+1];
   d2e_sqrt_type                   sq_data [SQ_CELLS+1];
   logic                           sq0_v_ff;
   d2e_side_type                   sq0_side_ff;
   d2e_sqrt_type                   sq0_data_ff;
   d2e_sqrt_type                   sq0_data_in;

   always_comb begin
      sum_sq = s2_sqx_ff + s2_sqz_ff;
      sq0_data_in.rad  = RAD_W'(sum_sq) << (2 * PRESCALE);
      sq0_data_in.rem  = '0;
      sq0_data_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         sq0_v_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_v_ff  <= req_tvalid;
         s2_v_ff  <= s1_v_ff;
         sq0_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_side_ff  <= s1_side_in;
         s2_side_ff  <= s1_side_ff;
         s2_sqx_ff   <= s2_sqx_in;
         s2_sqz_ff   <= s2_sqz_in;
         sq0_side_ff <= s2_side_ff;
         sq0_data_ff <= sq0_data_in;
      end
   end

   assign sq_v[0]    = sq0_v_ff;
   assign sq_side[0] = sq0_side_ff;
   assign sq_data[0] = sq0_data_ff;

   for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
      d2e_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (sq_v[i]),
         .in_side   (sq_side[i]),
         .in_data   (sq_data[i]),
         .out_valid (sq_v[i+1]),
         .out_side  (sq_side[i+1]),
         .out_data  (sq_data[i+1])
      );
   end

   // CORDIC chain: polar angle from (|y|, r), azimuth from (|x|, |z|).
   logic [ANGLE_STAGES:0] co_v;
   d2e_side_type          co_side  [ANGLE_STAGES+1];
   d2e_vec_type           co_theta [ANGLE_STAGES+1];
   d2e_vec_type           co_phi   [ANGLE_STAGES+1];

   assign co_v[0]    = sq_v[SQ_CELLS];
   assign co_side[0] = sq_side[SQ_CELLS];

   assign co_theta[0] = '{p:   VEC_W'(sq_side[SQ_CELLS].ay_s),
                          q:   VEC_W'(sq_data[SQ_CELLS].root),
                          ang: '0};
   assign co_phi[0]   = '{p:   VEC_W'(sq_side[SQ_CELLS].ax_s),
                          q:   VEC_W'(sq_side[SQ_CELLS].az_s),
                          ang: '0};

   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cordic
      d2e_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .in_valid  (co_v[i]),
         .in_side   (co_side[i]),
         .in_theta  (co_theta[i]),
         .in_phi    (co_phi[i]),
         .out_valid (co_v[i+1]),
         .out_side  (co_side[i+1]),
         .out_theta (co_theta[i+1]),
         .out_phi   (co_phi[i+1])
      );
   end

   // Unfold the first-quadrant angles and handle the axis cases.
   d2e_flags_type         fl;
   logic [ANGLE_BITS-1:0] beta;
   logic [ANGLE_BITS-1:0] alpha;
   logic                  fin_v_ff;
   logic [ANGLE_BITS-1:0] fin_theta_ff;
   logic [ANGLE_BITS-1:0] fin_theta_in;
   logic [ANGLE_BITS-1:0] fin_phi_ff;
   logic [ANGLE_BITS-1:0] fin_phi_in;

   always_comb begin
      fl    = co_side[ANGLE_STAGES].flags;
      alpha = clamp_angle(co_phi[ANGLE_STAGES].ang);
      // On the vertical axis the horizontal radius is zero.
      if (fl.x_zero && fl.z_zero) begin
         beta = '0;
      end else begin
         beta = clamp_angle(co_theta[ANGLE_STAGES].ang);
      end

      if (fl.y_zero) begin
         fin_theta_in = QUARTER_TURN;
      end else if (fl.y_neg) begin
         fin_theta_in = HALF_TURN - beta;
      end else begin
         fin_theta_in = beta;
      end

      if (fl.z_zero) begin
         fin_phi_in = fl.x_neg ? HALF_TURN : '0;
      end else if (fl.x_zero) begin
         fin_phi_in = fl.z_neg ? THREE_QUARTER_TURN : QUARTER_TURN;
      end else if (!fl.x_neg && !fl.z_neg) begin
         fin_phi_in = alpha;
      end else if (fl.x_neg && !fl.z_neg) begin
         fin_phi_in = HALF_TURN - alpha;
      end else if (fl.x_neg) begin
         fin_phi_in = HALF_TURN + alpha;
      end else begin
         fin_phi_in = ANGLE_BITS'(0) - alpha;
      end
   end

   // Scale the angles by the image size.
   logic              mul_v_ff;
   logic [MCOL_W-1:0] mul_col_ff;
   logic [MCOL_W-1:0] mul_col_in;
   logic [MROW_W-1:0] mul_row_ff;
   logic [MROW_W-1:0] mul_row_in;

   assign mul_col_in = MCOL_W'(fin_phi_ff) * MCOL_W'(tex_width_ff);
   assign mul_row_in = MROW_W'(fin_theta_ff) * MROW_W'(tex_height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
      end else if (pipe_en) begin
         fin_v_ff <= co_v[ANGLE_STAGES];
         mul_v_ff <= fin_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         fin_theta_ff <= fin_theta_in;
         fin_phi_ff   <= fin_phi_in;
         mul_col_ff   <= mul_col_in;
         mul_row_ff   <= mul_row_in;
      end
   end

   // A polar angle of a half turn lands one past the last row.
   logic [COL_W-1:0]    col;
   logic [RFULL_W-1:0]  row_full;
   logic [HEIGHT_W-1:0] row_sel;
   logic [RSP_W-1:0]    push_data;

   always_comb begin
      col      = mul_col_ff[ANGLE_BITS +: COL_W];
      row_full = mul_row_ff[ANGLE_BITS-1 +: RFULL_W];
      if (tex_height_ff == '0) begin
         row_sel = '0;
      end else if (row_full >= RFULL_W'(tex_height_ff)) begin
         row_sel = tex_height_ff - HEIGHT_W'(1);
      end else begin
         row_sel = row_full[HEIGHT_W-1:0];
      end
      push_data = RSP_W'({row_sel[ROW_W-1:0], col});
   end

   d2e_skid #(
      .WIDTH (RSP_W)
   ) u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (mul_v_ff),
      .push_data  (push_data),
      .stat       (skid_stat),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata)
   );

   // The second buffer entry is only ever used behind a waiting result.
   a_full_has_head : assert property (@(posedge clock) disable iff (reset)
      skid_stat.full |-> rsp_tvalid)
      else $error("output buffer spare entry held without a head entry");

   // An accepted item must appear in the first stage.
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_v_ff)
      else $error("accepted item did not enter the pipeline");

   // A stall must freeze the valid bit of every cell of both chains.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(sq_v) && $stable(co_v))
      else $error("pipeline moved during a stall");

endmodule

// ----- tb/tb_direction_to_equirect_pixel_core.sv -----
// Self-checking testbench for direction_to_equirect_pixel_core.
// Drives view directions on the req stream and checks the texel column and
// row on the rsp stream against a local predictor; depends on d2e_pkg.
module tb_direction_to_equirect_pixel_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORDIC_STAGES = 16;
   localparam int QUIET_LIMIT   = 3000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 84;
   localparam int PROBE_ROWS    = 25;

   localparam longint TURN_QUARTER       = 64'h4000_0000;
   localparam longint TURN_HALF          = 64'h8000_0000;
   localparam longint TURN_THREE_QUARTER = 64'hC000_0000;
   localparam longint TURN_FULL          = 64'h1_0000_0000;

   typedef struct {
      bit [13:0]          col;
      bit [12:0]          row;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } texel_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      bit                 known;
      bit [13:0]          col;
      bit [12:0]          row;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [d2e_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [d2e_pkg::CSR_IDX_W-1:0] csr_idx = '0;
   logic [d2e_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bit [13:0] tex_rows = 14'd1024;
   bit [14:0] tex_cols = 15'd2048;
   texel_type pending_texels [$];
   texel_type got_want;
   int fail_count = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   longint arc_step [CORDIC_STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861
   };

   // Axis cases and extremes; rows marked known carry their result directly.
   probe_row_type probe_table [PROBE_ROWS] = '{
      '{0, 0, 0, 1, 0, 512},
      '{0, 32767, 0, 1, 0, 0},
      '{0, 1, 0, 1, 0, 0},
      '{0, -32768, 0, 1, 0, 1023},
      '{0, -1, 0, 1, 0, 1023},
      '{32767, 0, 0, 1, 0, 512},
      '{1, 0, 0, 1, 0, 512},
      '{-32768, 0, 0, 1, 1024, 512},
      '{-1, 0, 0, 1, 1024, 512},
      '{0, 0, 32767, 1, 512, 512},
      '{0, 0, -32768, 1, 1536, 512},
      '{0, 0, -1, 1, 1536, 512},
      '{32767, 32767, 32767, 0, 0, 0},
      '{-32768, -32768, -32768, 0, 0, 0},
      '{1, 1, 1, 0, 0, 0},
      '{-1, -1, -1, 0, 0, 0},
      '{23170, 0, 23170, 0, 0, 0},
      '{-23170, 0, 23170, 0, 0, 0},
      '{-23170, 0, -23170, 0, 0, 0},
      '{23170, 0, -23170, 0, 0, 0},
      '{12345, -23456, -7890, 0, 0, 0},
      '{-20000, 5000, 20000, 0, 0, 0},
      '{-32768, 1, 32767, 0, 0, 0},
      '{32767, -1, -32768, 0, 0, 0},
      '{0, 16384, -16384, 0, 0, 0}
   };

   direction_to_equirect_pixel_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic bit [63:0] isqrt64(bit [63:0] v);
      bit [63:0] res;
      bit [63:0] probe;
      res   = '0;
      probe = 64'h1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Vectoring rotation on first-quadrant magnitudes: atan2(b, a) in binary angle units.
   function automatic longint quadrant_turns(longint a, longint b);
      longint p;
      longint q;
      longint dp;
      longint dq;
      longint ang;
      if (b == 0) return 0;
      if (a == 0) return TURN_QUARTER;
      p   = a;
      q   = b;
      ang = 0;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dp = p >>> i;
         dq = q >>> i;
         if (q >= 0) begin
            p   = p + dq;
            q   = q - dp;
            ang = ang + arc_step[i];
         end else begin
            p   = p - dq;
            q   = q + dp;
            ang = ang - arc_step[i];
         end
      end
      if (ang < 0) ang = 0;
      if (ang > TURN_QUARTER) ang = TURN_QUARTER;
      return ang;
   endfunction

   function automatic texel_type predict_texel(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z);
      texel_type t;
      longint ax;
      longint ay;
      longint az;
      longint r;
      longint theta;
      longint phi;
      longint alpha;
      longint beta;
      longint row;
      longint col;
      ax = (x < 0) ? -longint'(x) : longint'(x);
      ay = (y < 0) ? -longint'(y) : longint'(y);
      az = (z < 0) ? -longint'(z) : longint'(z);
      r  = longint'(isqrt64(64'(ax * ax + az * az) << 32));

      if (y == 0) begin
         theta = TURN_QUARTER;
      end else begin
         beta  = quadrant_turns(ay << 16, r);
         theta = (y > 0) ? beta : TURN_HALF - beta;
      end

      if (z == 0) begin
         phi = (x < 0) ? TURN_HALF : 0;
      end else if (x == 0) begin
         phi = (z > 0) ? TURN_QUARTER : TURN_THREE_QUARTER;
      end else begin
         alpha = quadrant_turns(ax << 16, az << 16);
         if (x > 0 && z > 0) phi = alpha;
         else if (x < 0 && z > 0) phi = TURN_HALF - alpha;
         else if (x < 0) phi = TURN_HALF + alpha;
         else phi = TURN_FULL - alpha;
         phi = phi & 64'hFFFF_FFFF;
      end

      if (tex_rows == 0) begin
         row = 0;
      end else begin
         row = (theta * longint'(tex_rows)) >> 31;
         if (row >= longint'(tex_rows)) row = longint'(tex_rows) - 1;
      end
      col = (tex_cols == 0) ? 0 : (phi * longint'(tex_cols)) >> 32;

      t.col = col[13:0];
      t.row = row[12:0];
      t.x   = x;
      t.y   = y;
      t.z   = z;
      return t;
   endfunction

   function automatic void flag_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endfunction

   // Axis values and extremes come up more often than a flat draw would give.
   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'sd0;
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         2: return 16'($urandom_range(0, 4)) - 16'sd2;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic maybe_gap();
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
   endtask

   task automatic offer_direction(input logic signed [15:0] x, input logic signed [15:0] y,
                                  input logic signed [15:0] z, input bit known,
                                  input bit [13:0] col, input bit [12:0] row);
      texel_type want;
      want = predict_texel(x, y, z);
      if (known) begin
         want.col = col;
         want.row = row;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_texels.push_back(want);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [d2e_pkg::CSR_IDX_W-1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= val[14:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == d2e_pkg::CSR_TEX_HEIGHT) tex_rows = val[13:0];
      else tex_cols = val[14:0];
   endtask

   initial begin
      int unsigned phase_rows [6];
      int unsigned phase_cols [6];
      phase_rows = '{1, 0, 32767, 8192, $urandom_range(1, 8192), 1024};
      phase_cols = '{1, 0, 32767, 16384, $urandom_range(1, 16384), 2048};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (probe_table[k]) begin
         maybe_gap();
         offer_direction(probe_table[k].x, probe_table[k].y, probe_table[k].z,
                         probe_table[k].known, probe_table[k].col, probe_table[k].row);
      end

      for (int ph = 0; ph < 6; ph++) begin
         wait_all_results();
         write_csr(d2e_pkg::CSR_TEX_HEIGHT, phase_rows[ph]);
         write_csr(d2e_pkg::CSR_TEX_WIDTH, phase_cols[ph]);
         if (ph == 5) idle_on = 1'b0;
         // The receiver stalls long here so the pipeline fills and backs up.
         if (ph == 1) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 2 && n == PHASE_ITEMS / 2) wait_all_results();
            maybe_gap();
            offer_direction(pick_coord(), pick_coord(), pick_coord(), 1'b0, '0, '0);
         end
      end

      wait_all_results();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending_texels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_texels.size() == 0) begin
            flag_failure($sformatf("unexpected item on rsp: col %0d row %0d",
                                   rsp_tdata[13:0], rsp_tdata[26:14]));
         end else begin
            got_want = pending_texels.pop_front();
            if (rsp_tdata[13:0] !== got_want.col || rsp_tdata[26:14] !== got_want.row) begin
               flag_failure($sformatf(
                  "mismatch for (%0d,%0d,%0d): col exp %0d got %0d, row exp %0d got %0d",
                  got_want.x, got_want.y, got_want.z, got_want.col, rsp_tdata[13:0],
                  got_want.row, rsp_tdata[26:14]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- files.f -----
sv/d2e_pkg.sv
sv/d2e_sqrt_cell.sv
sv/d2e_cordic_cell.sv
sv/d2e_skid.sv
sv/direction_to_equirect_pixel_core.sv
tb/tb_direction_to_equirect_pixel_core.sv
